### rtl/cdd_pkg.sv
// cdd_pkg: shared types and constants for the CSV delimiter detector.
// No dependencies; compiled first.
package cdd_pkg;

    // parameter defaults
    localparam int DEF_MAX_CANDIDATES = 4;
    localparam int DEF_HIST_ENTRIES   = 16;
    localparam int DEF_COUNT_BITS     = 16;

    // fixed field widths
    localparam int CAND_REGS = 4;
    localparam int UNIT_W    = 16;
    localparam int TALLY_W   = 16;
    localparam int LINES_W   = 16;
    localparam int NCAND_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 2;

    localparam logic [TALLY_W-1:0] TALLY_MAX   = '1;
    localparam logic [UNIT_W-1:0]  CR_UNIT     = 16'd13;
    localparam logic [LINES_W-1:0] SAMPLE_RST  = 16'd20;
    localparam logic [NCAND_W-1:0] NCAND_RST   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LINES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAND_0       = 3'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR = 2'd0,
        KIND_EOL  = 2'd1,
        KIND_EOD  = 2'd2
    } kind_t;

    // control from the sequencer to the per-line counters
    typedef struct packed {
        logic              count_en;
        logic              clear;
        logic [UNIT_W-1:0] code_unit;
    } line_ctl_t;

    // reset value of candidate register k
    function automatic logic [UNIT_W-1:0] cand_reset(input int k);
        logic [UNIT_W-1:0] v;
        case (k)
            0:       v = 16'd44;
            1:       v = 16'd9;
            2:       v = 16'd59;
            3:       v = 16'd124;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/cdd_if.sv
// cdd_if: request and result channel interfaces (valid/ready + payload).
// Depends on cdd_pkg.
interface cdd_item_if;
    logic                        valid;
    logic                        ready;
    logic [cdd_pkg::KIND_W-1:0]  kind;
    logic [cdd_pkg::UNIT_W-1:0]  code_unit;

    modport source (output valid, kind, code_unit, input ready);
    modport sink   (input valid, kind, code_unit, output ready);
endinterface

interface cdd_result_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [cdd_pkg::INDEX_W-1:0]  candidate_index;
    logic [cdd_pkg::UNIT_W-1:0]   delimiter;
    logic [cdd_pkg::TALLY_W-1:0]  best_tally;
    logic                         histogram_overflow;

    modport source (output valid, found, candidate_index, delimiter, best_tally,
                    histogram_overflow, input ready);
    modport sink   (input valid, found, candidate_index, delimiter, best_tally,
                    histogram_overflow, output ready);
endinterface

### rtl/csv_delimiter_detector_core.sv
// csv_delimiter_detector_core: top level; config registers, sequencer and
// shared compare/increment unit over the histogram RAM.
// Depends on cdd_pkg, cdd_if, cdd_ram, cdd_line_counter.

// A character request is taken in idle and the block stays ready for the
// next one. An end-of-line request inside the sample walks the active
// candidates one at a time: a candidate with a zero count is skipped,
// otherwise the histogram of that candidate is read one entry per cycle
// until the count matches or a new entry is appended (or the overflow flag
// is set when the histogram is full). A line end outside the sample only
// clears the line counts. An end of document scans every filled histogram
// entry of the active candidates once, one per cycle, then waits until the
// result register is free. The histogram RAM has a single read port.
// Histogram entries are allocated in order, so a fill count per candidate
// marks the live entries and no clearing pass is needed. Results sit in an
// output register; the block keeps taking characters and line ends while a
// result waits to be taken.
module csv_delimiter_detector_core #(
    parameter int MAX_CANDIDATES = cdd_pkg::DEF_MAX_CANDIDATES,
    parameter int HIST_ENTRIES   = cdd_pkg::DEF_HIST_ENTRIES,
    parameter int COUNT_BITS     = cdd_pkg::DEF_COUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdd_pkg::CFG_W-1:0]     cfg_data,
    cdd_item_if.sink                      item,
    cdd_result_if.source                  result
);

    // lanes actually reachable through the candidate registers
    localparam int NL      = (MAX_CANDIDATES < cdd_pkg::CAND_REGS) ?
                             MAX_CANDIDATES : cdd_pkg::CAND_REGS;
    localparam int CIDX_W  = (NL > 1) ? $clog2(NL) : 1;
    localparam int CCW     = $clog2(NL + 1);
    localparam int EW      = (HIST_ENTRIES > 1) ? $clog2(HIST_ENTRIES) : 1;
    localparam int FW      = $clog2(HIST_ENTRIES + 1);
    localparam int AW      = CIDX_W + EW;
    localparam int RAM_W   = COUNT_BITS + cdd_pkg::TALLY_W;
    localparam int TW      = cdd_pkg::TALLY_W;
    localparam int LW      = cdd_pkg::LINES_W;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_REC_NEXT  = 7'b0000010,
        ST_REC_CMP   = 7'b0000100,
        ST_REC_ALLOC = 7'b0001000,
        ST_SCAN_NEXT = 7'b0010000,
        ST_SCAN_CMP  = 7'b0100000,
        ST_FINISH    = 7'b1000000
    } state_t;

    // configuration
    logic [LW-1:0]                    sample_reg;
    logic [cdd_pkg::NCAND_W-1:0]      ncand_reg;
    logic [cdd_pkg::UNIT_W-1:0]       cand_reg [NL];
    logic [CCW-1:0]                   n_active;

    // sequencer and document state
    state_t          state_reg, state_next;
    logic [CCW-1:0]  c_reg, c_next;
    logic [EW-1:0]   e_reg, e_next;
    logic [FW-1:0]   fill_reg [NL];
    logic [FW-1:0]   fill_next [NL];
    logic [LW-1:0]   lines_reg, lines_next;
    logic            ovf_reg, ovf_next;
    logic [TW-1:0]   best_reg, best_next;
    logic [CIDX_W-1:0] win_reg, win_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          out_found_reg, out_found_next;
    logic [cdd_pkg::INDEX_W-1:0]   out_index_reg, out_index_next;
    logic [cdd_pkg::UNIT_W-1:0]    out_delim_reg, out_delim_next;
    logic [TW-1:0]                 out_tally_reg, out_tally_next;
    logic                          out_ovf_reg, out_ovf_next;

    // datapath
    cdd_pkg::line_ctl_t line_ctl;
    logic [COUNT_BITS-1:0] line_count [NL];
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [RAM_W-1:0]      ram_wdata, ram_rdata;
    logic [COUNT_BITS-1:0] rd_count;
    logic [TW-1:0]         rd_tally;
    logic [CIDX_W-1:0]     c_idx;
    logic [COUNT_BITS-1:0] cur_count;
    logic [FW-1:0]         cur_fill;
    logic [FW-1:0]         e_inc;
    logic                  in_sample;
    logic                  found;

    // ------------------------------------------------------------------
    // configuration registers; writes beyond the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= cdd_pkg::SAMPLE_RST;
            ncand_reg  <= cdd_pkg::NCAND_RST;
            for (int k = 0; k < NL; k++)
            begin
                cand_reg[k] <= cdd_pkg::cand_reset(k);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == cdd_pkg::REG_SAMPLE_LINES)
            begin
                sample_reg <= cfg_data;
            end
            if (cfg_index == cdd_pkg::REG_NUM_CAND)
            begin
                ncand_reg <= cfg_data[cdd_pkg::NCAND_W-1:0];
            end
            for (int k = 0; k < NL; k++)
            begin
                if (cfg_index == cdd_pkg::REG_CAND_0 + cdd_pkg::CFG_IDX_W'(k))
                begin
                    cand_reg[k] <= cfg_data;
                end
            end
        end
    end

    // active candidates saturate at the lane count
    assign n_active = (ncand_reg > cdd_pkg::NCAND_W'(NL)) ? CCW'(NL) : CCW'(ncand_reg);

    // ------------------------------------------------------------------
    // per-line counters and histogram store
    // ------------------------------------------------------------------
    cdd_line_counter #(
        .NL (NL),
        .CW (COUNT_BITS)
    ) u_line_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (line_ctl),
        .cand  (cand_reg),
        .count (line_count)
    );

    // entry {candidate, slot} holds {count, tally}
    cdd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (1 << AW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_count  = ram_rdata[RAM_W-1:TW];
    assign rd_tally  = ram_rdata[TW-1:0];
    assign c_idx     = c_reg[CIDX_W-1:0];
    assign cur_count = line_count[c_idx];
    assign cur_fill  = fill_reg[c_idx];
    assign e_inc     = FW'(e_reg) + 1'b1;
    assign in_sample = (lines_reg < sample_reg);

    // consistency test: twice the best tally must reach the line count
    assign found = (best_reg != '0) && (lines_reg != '0) &&
                   ({best_reg, 1'b0} >= {1'b0, lines_reg});

    assign item.ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        e_next         = e_reg;
        fill_next      = fill_reg;
        lines_next     = lines_reg;
        ovf_next       = ovf_reg;
        best_next      = best_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_delim_next = out_delim_reg;
        out_tally_next = out_tally_reg;
        out_ovf_next   = out_ovf_reg;
        line_ctl.count_en  = 1'b0;
        line_ctl.clear     = 1'b0;
        line_ctl.code_unit = item.code_unit;
        ram_we    = 1'b0;
        ram_waddr = {c_idx, e_reg};
        ram_wdata = {cur_count, TW'(1)};
        ram_raddr = {c_idx, EW'(0)};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    case (item.kind)
                        cdd_pkg::KIND_CHAR:
                        begin
                            line_ctl.count_en = in_sample;
                        end
                        cdd_pkg::KIND_EOL:
                        begin
                            if (in_sample)
                            begin
                                c_next     = '0;
                                state_next = ST_REC_NEXT;
                            end
                            else
                            begin
                                line_ctl.clear = 1'b1;
                            end
                        end
                        cdd_pkg::KIND_EOD:
                        begin
                            c_next     = '0;
                            best_next  = '0;
                            win_next   = '0;
                            state_next = ST_SCAN_NEXT;
                        end
                        default:
                        begin
                            // unused kind code: dropped
                        end
                    endcase
                end
            end

            ST_REC_NEXT:
            begin
                if (c_reg >= n_active)
                begin
                    lines_next     = lines_reg + 1'b1;
                    line_ctl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (cur_count == '0)
                begin
                    c_next = c_reg + 1'b1;
                end
                else if (cur_fill == '0)
                begin
                    state_next = ST_REC_ALLOC;
                end
                else
                begin
                    e_next     = '0;
                    state_next = ST_REC_CMP;
                end
            end

            ST_REC_CMP:
            begin
                if (rd_count == cur_count)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {rd_count,
                                  (rd_tally == cdd_pkg::TALLY_MAX) ? rd_tally
                                                                   : rd_tally + 1'b1};
                    c_next     = c_reg + 1'b1;
                    state_next = ST_REC_NEXT;
                end
                else if (e_inc < cur_fill)
                begin
                    ram_raddr = {c_idx, e_inc[EW-1:0]};
                    e_next    = e_inc[EW-1:0];
                end
                else
                begin
                    state_next = ST_REC_ALLOC;
                end
            end

            ST_REC_ALLOC:
            begin
                if (cur_fill < FW'(HIST_ENTRIES))
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = {c_idx, cur_fill[EW-1:0]};
                    fill_next[c_idx]  = cur_fill + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                c_next     = c_reg + 1'b1;
                state_next = ST_REC_NEXT;
            end

            ST_SCAN_NEXT:
            begin
                if (c_reg >= n_active)
                begin
                    state_next = ST_FINISH;
                end
                else if (cur_fill == '0)
                begin
                    c_next = c_reg + 1'b1;
                end
                else
                begin
                    e_next     = '0;
                    state_next = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP:
            begin
                // strict compare: earlier candidate keeps a tie
                if (rd_tally > best_reg)
                begin
                    best_next = rd_tally;
                    win_next  = c_idx;
                end
                if (e_inc < cur_fill)
                begin
                    ram_raddr = {c_idx, e_inc[EW-1:0]};
                    e_next    = e_inc[EW-1:0];
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_SCAN_NEXT;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found;
                    out_index_next = found ? cdd_pkg::INDEX_W'(win_reg) : '0;
                    out_delim_next = found ? cand_reg[win_reg] : '0;
                    out_tally_next = best_reg;
                    out_ovf_next   = ovf_reg;
                    // document state clears behind the result
                    for (int k = 0; k < NL; k++)
                    begin
                        fill_next[k] = '0;
                    end
                    lines_next     = '0;
                    ovf_next       = 1'b0;
                    line_ctl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            c_reg         <= '0;
            e_reg         <= '0;
            lines_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NL; k++)
            begin
                fill_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            c_reg         <= c_next;
            e_reg         <= e_next;
            lines_reg     <= lines_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        win_reg       <= win_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_delim_reg <= out_delim_next;
        out_tally_reg <= out_tally_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.found              = out_found_reg;
    assign result.candidate_index    = out_index_reg;
    assign result.delimiter          = out_delim_reg;
    assign result.best_tally         = out_tally_reg;
    assign result.histogram_overflow = out_ovf_reg;

endmodule

### rtl/cdd_ram.sv
// cdd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cdd_line_counter.sv
// cdd_line_counter: per-candidate occurrence counters for the current line,
// with carriage-return hold. Depends on cdd_pkg.
module cdd_line_counter #(
    parameter int NL = 4,
    parameter int CW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cdd_pkg::line_ctl_t         ctl,
    input  logic [cdd_pkg::UNIT_W-1:0] cand [NL],
    output logic [CW-1:0]              count [NL]
);

    logic [CW-1:0] count_reg [NL];
    logic          pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            for (int k = 0; k < NL; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            pending_reg <= 1'b0;
            for (int k = 0; k < NL; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (ctl.count_en)
        begin
            // held CR counts now; a new CR is held in turn
            pending_reg <= (ctl.code_unit == cdd_pkg::CR_UNIT);
            for (int k = 0; k < NL; k++)
            begin
                if (((pending_reg && cand[k] == cdd_pkg::CR_UNIT) ||
                     (ctl.code_unit != cdd_pkg::CR_UNIT && cand[k] == ctl.code_unit)) &&
                    count_reg[k] != '1)
                begin
                    count_reg[k] <= count_reg[k] + 1'b1;
                end
            end
        end
    end

    assign count = count_reg;

endmodule

### rtl/cdd_checker.sv
// cdd_checker: port-level assertions for csv_delimiter_detector_core,
// bound to the top level. Depends on cdd_pkg.
module cdd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic [cdd_pkg::KIND_W-1:0]   item_kind,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         result_found,
    input logic [cdd_pkg::INDEX_W-1:0]  result_candidate_index,
    input logic [cdd_pkg::UNIT_W-1:0]   result_delimiter,
    input logic [cdd_pkg::TALLY_W-1:0]  result_best_tally
);

    // a pending result is not withdrawn
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result withdrawn before it was taken");

    // no winner means index and delimiter report zero
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_found |->
            result_candidate_index == '0 && result_delimiter == '0)
        else $error("index or delimiter nonzero without a winner");

    // a winner covers at least one line
    a_found_tally: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_found |-> result_best_tally != '0)
        else $error("winner reported with zero tally");

    // end of document starts the histogram scan, so the block is busy next
    a_eod_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_kind == cdd_pkg::KIND_EOD |=> !item_ready)
        else $error("ready right after end of document");

endmodule

bind csv_delimiter_detector_core cdd_checker u_cdd_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .item_valid             (item.valid),
    .item_ready             (item.ready),
    .item_kind              (item.kind),
    .result_valid           (result.valid),
    .result_ready           (result.ready),
    .result_found           (result.found),
    .result_candidate_index (result.candidate_index),
    .result_delimiter       (result.delimiter),
    .result_best_tally      (result.best_tally)
);

### verif/tb_csv_delimiter_detector_core.sv
// Self-checking testbench for csv_delimiter_detector_core: streams documents,
// predicts each detection verdict in a scoreboard class and checks the results.
// Depends on cdd_pkg, cdd_if and the detector RTL.
module tb_csv_delimiter_detector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CAND = cdd_pkg::DEF_MAX_CANDIDATES;
    localparam int HIST_N   = cdd_pkg::DEF_HIST_ENTRIES;
    localparam int CNT_W    = cdd_pkg::DEF_COUNT_BITS;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // kind 3 has no name in the package; the block must drop it
    localparam logic [cdd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // index 6 and 7 decode to nothing
    localparam logic [cdd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [cdd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [cdd_pkg::UNIT_W-1:0] COMMA = 16'd44;
    localparam logic [cdd_pkg::UNIT_W-1:0] TAB   = 16'd9;
    localparam logic [cdd_pkg::UNIT_W-1:0] SEMI  = 16'd59;
    localparam logic [cdd_pkg::UNIT_W-1:0] PIPE  = 16'd124;

    // settle time covers the longest line-end walk, rounded up generously
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int MIN_DOCS      = 50;
    localparam int STALL_PCT     = 26;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the config registers and the document state,
    // turns each end of document into the verdict it should produce and
    // compares the verdicts coming out of the block in order.
    // ------------------------------------------------------------------
    class delimiter_tracker;
        logic [cdd_pkg::LINES_W-1:0] sample_lines;
        logic [cdd_pkg::NCAND_W-1:0] num_cand;
        logic [cdd_pkg::UNIT_W-1:0]  cand [MAX_CAND];

        logic [CNT_W-1:0]            line_count [MAX_CAND];
        bit                          slot_used  [MAX_CAND][HIST_N];
        logic [CNT_W-1:0]            slot_count [MAX_CAND][HIST_N];
        logic [cdd_pkg::TALLY_W-1:0] slot_tally [MAX_CAND][HIST_N];
        logic [cdd_pkg::LINES_W-1:0] lines_seen;
        bit                          cr_held;
        bit                          overflow;

        typedef struct packed {
            logic                        found;
            logic [cdd_pkg::INDEX_W-1:0] candidate_index;
            logic [cdd_pkg::UNIT_W-1:0]  delimiter;
            logic [cdd_pkg::TALLY_W-1:0] best_tally;
            logic                        histogram_overflow;
        } verdict_t;

        verdict_t verdicts [$];

        int mismatches;
        int checked;
        int found_hits;
        int overflow_hits;

        function new();
            int c;
            sample_lines = cdd_pkg::SAMPLE_RST;
            num_cand     = cdd_pkg::NCAND_RST;
            for (c = 0; c < MAX_CAND; c++)
                cand[c] = '0;
            cand[0] = COMMA;
            if (MAX_CAND > 1) cand[1] = TAB;
            if (MAX_CAND > 2) cand[2] = SEMI;
            if (MAX_CAND > 3) cand[3] = PIPE;
            mismatches    = 0;
            checked       = 0;
            found_hits    = 0;
            overflow_hits = 0;
            clear_doc();
        endfunction

        function void clear_line();
            int c;
            for (c = 0; c < MAX_CAND; c++)
                line_count[c] = '0;
            cr_held = 1'b0;
        endfunction

        function void clear_doc();
            int c, e;
            clear_line();
            for (c = 0; c < MAX_CAND; c++)
                for (e = 0; e < HIST_N; e++)
                    slot_used[c][e] = 1'b0;
            lines_seen = '0;
            overflow   = 1'b0;
        endfunction

        function void set_reg(logic [cdd_pkg::CFG_IDX_W-1:0] idx,
                              logic [cdd_pkg::CFG_W-1:0] data);
            int k;
            if (idx == cdd_pkg::REG_SAMPLE_LINES)
                sample_lines = data[cdd_pkg::LINES_W-1:0];
            else if (idx == cdd_pkg::REG_NUM_CAND)
                num_cand = data[cdd_pkg::NCAND_W-1:0];
            else if (idx >= cdd_pkg::REG_CAND_0 &&
                     idx < cdd_pkg::REG_CAND_0 + cdd_pkg::CAND_REGS)
            begin
                k = idx - cdd_pkg::REG_CAND_0;
                if (k < MAX_CAND)
                    cand[k] = data[cdd_pkg::UNIT_W-1:0];
            end
        endfunction

        function int active();
            int n;
            n = num_cand;
            if (n > MAX_CAND) n = MAX_CAND;
            if (n > cdd_pkg::CAND_REGS) n = cdd_pkg::CAND_REGS;
            return n;
        endfunction

        // every candidate counts, active or not; only filing is limited
        function void bump(logic [cdd_pkg::UNIT_W-1:0] u);
            int c;
            for (c = 0; c < MAX_CAND; c++)
                if (cand[c] == u && line_count[c] != COUNT_MAX)
                    line_count[c]++;
        endfunction

        function void file_count(int c, logic [CNT_W-1:0] cnt);
            int e, free_e;
            free_e = -1;
            for (e = 0; e < HIST_N; e++)
            begin
                if (slot_used[c][e])
                begin
                    if (slot_count[c][e] == cnt)
                    begin
                        if (slot_tally[c][e] != cdd_pkg::TALLY_MAX)
                            slot_tally[c][e]++;
                        return;
                    end
                end
                else if (free_e < 0)
                    free_e = e;
            end
            if (free_e < 0)
            begin
                overflow = 1'b1;
                return;
            end
            slot_used[c][free_e]  = 1'b1;
            slot_count[c][free_e] = cnt;
            slot_tally[c][free_e] = 1;
        endfunction

        function logic [cdd_pkg::TALLY_W-1:0] top_tally(int c);
            int e;
            logic [cdd_pkg::TALLY_W-1:0] best;
            best = '0;
            for (e = 0; e < HIST_N; e++)
                if (slot_used[c][e] && slot_tally[c][e] > best)
                    best = slot_tally[c][e];
            return best;
        endfunction

        // returns 1 when the request changed the document state
        function bit note_request(logic [cdd_pkg::KIND_W-1:0] req_kind,
                                  logic [cdd_pkg::UNIT_W-1:0] u);
            int c, n, win;
            bit any, live;
            logic [cdd_pkg::TALLY_W-1:0] best, s;
            verdict_t v;
            n    = active();
            live = 1'b0;
            if (req_kind == cdd_pkg::KIND_CHAR)
            begin
                if (lines_seen >= sample_lines)
                    return 1'b0;
                if (cr_held)
                begin
                    bump(cdd_pkg::CR_UNIT);
                    cr_held = 1'b0;
                end
                if (u == cdd_pkg::CR_UNIT)
                    cr_held = 1'b1;
                else
                    bump(u);
                live = 1'b1;
            end
            else if (req_kind == cdd_pkg::KIND_EOL)
            begin
                if (lines_seen < sample_lines)
                begin
                    for (c = 0; c < n; c++)
                        if (line_count[c] != 0)
                            file_count(c, line_count[c]);
                    lines_seen++;
                    live = 1'b1;
                end
                clear_line();
            end
            else if (req_kind == cdd_pkg::KIND_EOD)
            begin
                best = '0;
                win  = 0;
                any  = 1'b0;
                for (c = 0; c < n; c++)
                begin
                    s = top_tally(c);
                    if (s > best)
                    begin
                        best = s;
                        win  = c;
                        any  = 1'b1;
                    end
                end
                v.found = any && lines_seen != 0 && 2 * int'(best) >= int'(lines_seen);
                v.candidate_index    = v.found ? cdd_pkg::INDEX_W'(win) : '0;
                v.delimiter          = v.found ? cand[win] : '0;
                v.best_tally         = best;
                v.histogram_overflow = overflow;
                verdicts.push_back(v);
                clear_doc();
                live = 1'b1;
            end
            return live;
        endfunction

        function void check_result(logic f, logic [cdd_pkg::INDEX_W-1:0] idx,
                                   logic [cdd_pkg::UNIT_W-1:0] d,
                                   logic [cdd_pkg::TALLY_W-1:0] t, logic ov);
            verdict_t want;
            if (verdicts.size() == 0)
            begin
                $error("result with no request outstanding: found=%0d index=%0d", f, idx);
                mismatches++;
                return;
            end
            want = verdicts.pop_front();
            checked++;
            if (want.found) found_hits++;
            if (want.histogram_overflow) overflow_hits++;
            if (f !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, f);
                mismatches++;
            end
            if (idx !== want.candidate_index)
            begin
                $error("candidate_index: expected %0d, got %0d", want.candidate_index, idx);
                mismatches++;
            end
            if (d !== want.delimiter)
            begin
                $error("delimiter: expected %0d, got %0d", want.delimiter, d);
                mismatches++;
            end
            if (t !== want.best_tally)
            begin
                $error("best_tally: expected %0d, got %0d", want.best_tally, t);
                mismatches++;
            end
            if (ov !== want.histogram_overflow)
            begin
                $error("histogram_overflow: expected %0d, got %0d",
                       want.histogram_overflow, ov);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic                          cfg_we;
    logic [cdd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cdd_pkg::CFG_W-1:0]     cfg_data;

    always #10 clk = ~clk;

    cdd_item_if   item_ch ();
    cdd_result_if result_ch ();

    csv_delimiter_detector_core #(
        .MAX_CANDIDATES (MAX_CAND),
        .HIST_ENTRIES   (HIST_N),
        .COUNT_BITS     (CNT_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    delimiter_tracker tracker = new();

    bit steady = 1'b0;     // when set neither side stalls
    int live_requests = 0; // requests that changed document state
    int docs_sent = 0;
    int cfg_phases = 0;

    // ------------------------------------------------------------------
    // Result side: ready is redrawn at every falling edge; verdicts are
    // taken at the rising edge where valid and ready meet.
    // ------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            tracker.check_result(result_ch.found, result_ch.candidate_index,
                                 result_ch.delimiter, result_ch.best_tally,
                                 result_ch.histogram_overflow);
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #60ms;
        $display("** csv_delimiter_detector_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver. Entered and left on a falling edge, so valid gets
    // one assignment per step even when requests run back to back.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [cdd_pkg::KIND_W-1:0] k,
                                input logic [cdd_pkg::UNIT_W-1:0] u);
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= k;
        item_ch.code_unit <= u;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (tracker.note_request(k, u))
            live_requests++;
        if (k == cdd_pkg::KIND_EOD)
            docs_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [cdd_pkg::UNIT_W-1:0] u);
        send_request(cdd_pkg::KIND_CHAR, u);
    endtask

    // Drop valid, wait for nothing outstanding, then room for a line end
    // with no result to finish.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (tracker.verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [cdd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cdd_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Full register set, written only once the block has gone quiet.
    task automatic program_regs(input logic [cdd_pkg::LINES_W-1:0] sl,
                                input logic [cdd_pkg::NCAND_W-1:0] nc,
                                input logic [cdd_pkg::UNIT_W-1:0] c0,
                                input logic [cdd_pkg::UNIT_W-1:0] c1,
                                input logic [cdd_pkg::UNIT_W-1:0] c2,
                                input logic [cdd_pkg::UNIT_W-1:0] c3,
                                input bit spare_too);
        wait_idle();
        write_reg(cdd_pkg::REG_SAMPLE_LINES, sl);
        write_reg(cdd_pkg::REG_NUM_CAND, cdd_pkg::CFG_W'(nc));
        write_reg(cdd_pkg::REG_CAND_0, c0);
        write_reg(cdd_pkg::REG_CAND_0 + 3'd1, c1);
        write_reg(cdd_pkg::REG_CAND_0 + 3'd2, c2);
        write_reg(cdd_pkg::REG_CAND_0 + 3'd3, c3);
        if (spare_too)
        begin
            write_reg(REG_SPARE_LO, cdd_pkg::CFG_W'($urandom_range(65535)));
            write_reg(REG_SPARE_HI, cdd_pkg::CFG_W'($urandom_range(65535)));
        end
        cfg_we <= 1'b0;
        @(negedge clk);
        cfg_phases++;
    endtask

    // Delimiter-ish values; duplicates are welcome, they exercise ties.
    function automatic logic [cdd_pkg::UNIT_W-1:0] pick_delim_value();
        case ($urandom_range(9))
            0:       return COMMA;
            1:       return TAB;
            2:       return SEMI;
            3:       return PIPE;
            4:       return cdd_pkg::CR_UNIT;
            5:       return '0;
            6:       return '1;
            7:       return cdd_pkg::UNIT_W'($urandom_range(65535));
            default: return cdd_pkg::UNIT_W'($urandom_range(32, 126));
        endcase
    endfunction

    // Text content: mostly live candidates and printable filler.
    function automatic logic [cdd_pkg::UNIT_W-1:0] pick_unit();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return tracker.cand[$urandom_range(MAX_CAND - 1)];
        if (r < 48)
            return cdd_pkg::CR_UNIT;
        if (r < 58)
            return cdd_pkg::UNIT_W'($urandom_range(65535));
        return cdd_pkg::UNIT_W'($urandom_range(32, 126));
    endfunction

    task automatic random_config();
        int r;
        logic [cdd_pkg::LINES_W-1:0] sl;
        logic [cdd_pkg::NCAND_W-1:0] nc;
        r = $urandom_range(99);
        if (r < 8)
            sl = '0;
        else if (r < 16)
            sl = '1;
        else if (r < 24)
            sl = 16'd1;
        else
            sl = cdd_pkg::LINES_W'($urandom_range(2, 24));
        nc = ($urandom_range(99) < 40) ? cdd_pkg::NCAND_W'(4)
                                       : cdd_pkg::NCAND_W'($urandom_range(0, 7));
        program_regs(sl, nc, pick_delim_value(), pick_delim_value(), pick_delim_value(),
                     pick_delim_value(), $urandom_range(3) == 0);
    endtask

    // One document. Most are consistent (same delimiter count per line,
    // with the odd drift), some are staircases of rising counts that fill
    // the histogram, the rest are noise.
    task automatic random_document();
        int mode, nlines, ln, i, len, rem, base_m, m_line;
        logic [cdd_pkg::UNIT_W-1:0] fav;
        mode   = $urandom_range(99);
        nlines = ($urandom_range(9) == 0) ? $urandom_range(11, 22) : $urandom_range(0, 10);
        if (mode >= 60 && mode < 75)
            nlines = $urandom_range(15, 21);
        fav    = tracker.cand[$urandom_range(MAX_CAND - 1)];
        base_m = $urandom_range(0, 4);
        for (ln = 0; ln < nlines; ln++)
        begin
            if (mode < 75)
            begin
                if (mode < 60)
                    m_line = ($urandom_range(9) == 0) ? $urandom_range(0, 5) : base_m;
                else
                    m_line = ln + 1;
                len = m_line + $urandom_range(0, 4);
                rem = m_line;
                for (i = 0; i < len; i++)
                begin
                    if (rem > 0 && $urandom_range(len - i - 1) < rem)
                    begin
                        send_char(fav);
                        rem--;
                    end
                    else
                        send_char(pick_unit());
                end
            end
            else
            begin
                len = $urandom_range(0, 8);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(11) == 0)
                        send_request(KIND_UNUSED,
                                     cdd_pkg::UNIT_W'($urandom_range(65535)));
                    send_char(pick_unit());
                end
            end
            // trailing CR must vanish at the line end
            if ($urandom_range(7) == 0)
                send_char(cdd_pkg::CR_UNIT);
            if ($urandom_range(19) == 0)
                send_request(KIND_UNUSED, cdd_pkg::UNIT_W'($urandom_range(65535)));
            send_request(cdd_pkg::KIND_EOL, cdd_pkg::UNIT_W'($urandom_range(65535)));
        end
        // unterminated tail gets thrown away
        if ($urandom_range(5) == 0)
        begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++)
                send_char(pick_unit());
        end
        send_request(cdd_pkg::KIND_EOD, cdd_pkg::UNIT_W'($urandom_range(65535)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int doc_no;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = cdd_pkg::KIND_CHAR;
        item_ch.code_unit = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset config: two lines of commas, the second with a
        // CR right before the line end, then a tail with no line end.
        send_char(COMMA);
        send_char(16'd97);
        send_char(COMMA);
        send_request(cdd_pkg::KIND_EOL, '0);
        send_char(COMMA);
        send_char(cdd_pkg::CR_UNIT);
        send_request(cdd_pkg::KIND_EOL, '1);
        send_char(COMMA);
        send_char(COMMA);
        send_request(cdd_pkg::KIND_EOD, '0);

        // CR as a delimiter, both code-unit extremes as delimiters, a
        // candidate count above the register count, unmapped indexes,
        // an unknown kind and lines beyond the sample limit.
        program_regs(16'd2, 3'd7, cdd_pkg::CR_UNIT, '1, '0, PIPE, 1'b1);
        send_char(cdd_pkg::CR_UNIT);
        send_char(16'd120);
        send_char('1);
        send_char('0);
        send_request(cdd_pkg::KIND_EOL, '0);
        send_char(cdd_pkg::CR_UNIT);
        send_char(cdd_pkg::CR_UNIT);
        send_request(cdd_pkg::KIND_EOL, '0);
        send_request(KIND_UNUSED, '1);
        send_char(PIPE);
        send_request(cdd_pkg::KIND_EOL, '0);
        send_char(COMMA);
        send_request(cdd_pkg::KIND_EOD, '1);

        // Nothing sampled, nothing active.
        program_regs('0, '0, COMMA, TAB, SEMI, PIPE, 1'b0);
        send_char(COMMA);
        send_request(cdd_pkg::KIND_EOL, '0);
        send_request(cdd_pkg::KIND_EOD, '0);

        // Random documents; config changes every few documents, each time
        // after draining, and one stretch runs with no stalls at all.
        live_requests = 0;
        doc_no = 0;
        while (live_requests < RANDOM_ITEMS || doc_no < MIN_DOCS)
        begin
            if (doc_no % 5 == 0)
                random_config();
            steady = (doc_no >= 12 && doc_no < 20);
            random_document();
            doc_no++;
        end
        steady = 1'b0;

        wait_idle();

        if (tracker.verdicts.size() != 0)
        begin
            $error("%0d verdicts never arrived", tracker.verdicts.size());
            tracker.mismatches++;
        end

        $display("Covered %0d documents in %0d config phases; %0d verdicts checked.",
                 docs_sent, cfg_phases, tracker.checked);
        $display("Delimiter found in %0d of them, histogram overflow in %0d.",
                 tracker.found_hits, tracker.overflow_hits);
        if (tracker.mismatches == 0)
            $display("** csv_delimiter_detector_core: PASSED **");
        else
            $display("** csv_delimiter_detector_core: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/cdd_pkg.sv
rtl/cdd_if.sv
rtl/cdd_ram.sv
rtl/cdd_line_counter.sv
rtl/csv_delimiter_detector_core.sv
rtl/cdd_checker.sv
verif/tb_csv_delimiter_detector_core.sv
